// File: src/par_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// par_pkg: shared definitions for the principal axis rotation block
// Holds the default sizes, the axis and quadrant codes, the CORDIC vector
// type and the elaboration-time functions for the arctangent and gain
// constants in Q60 and Q61 fixed point.
// ---------------------------------------------------------------------------
package par_pkg;

   // Default sizes of the top level.
   localparam int DEF_COORD_WIDTH = 32;
   localparam int DEF_ANGLE_WIDTH = 16;
   localparam int DEF_ITERATIONS  = 18;

   // Rotation axis codes carried in the opcode field.
   localparam logic [1:0] AXIS_X    = 2'd0;
   localparam logic [1:0] AXIS_Y    = 2'd1;
   localparam logic [1:0] AXIS_Z    = 2'd2;
   localparam logic [1:0] AXIS_NONE = 2'd3;

   // Quadrant codes taken from the two top angle bits.
   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;
   localparam logic [1:0] QUAD_3 = 2'd3;

   // Fixed-point constants.
   localparam logic signed [63:0] PI_Q60    = 64'sh3243_F6A8_885A_308D;
   localparam logic signed [63:0] ONE_Q61   = 64'sh2000_0000_0000_0000;
   localparam logic signed [63:0] THREE_Q61 = 64'sd3 * ONE_Q61;
   localparam logic signed [63:0] GAIN_SEED = THREE_Q61 / 5;

   // Vector handed from one CORDIC cell to the next: X, Y in Q61, angle in Q60.
   typedef struct packed {
      logic signed [63:0] cx;
      logic signed [63:0] cy;
      logic signed [63:0] ang;
   } cordic_type;

   // Quotient of 2^m by d, by restoring long division.
   function automatic logic [63:0] pow2_div(input int m, input int d);
      logic [63:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], (b == m)};
         if (rem >= 64'(d)) begin
            rem = rem - 64'(d);
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // Arctangent of 2^-i in Q60, from the truncated series.
   function automatic logic signed [63:0] atan_q60(input int i);
      logic signed [63:0] sum;
      int n;
      sum = '0;
      n = 0;
      if (i == 0) begin
         sum = PI_Q60 >>> 2;
      end else begin
         for (int k = 0; k < 31; k++) begin
            n = i * (2 * k + 1);
            if (n <= 60) begin
               if ((k & 1) != 0) begin
                  sum = sum - $signed(pow2_div(60 - n, 2 * k + 1));
               end else begin
                  sum = sum + $signed(pow2_div(60 - n, 2 * k + 1));
               end
            end
         end
      end
      return sum;
   endfunction

   // Floor of a*b / 2^s from the exact product.
   function automatic logic signed [63:0] mul_shift_c(input logic signed [63:0] a,
                                                      input logic signed [63:0] b,
                                                      input int s);
      logic signed [127:0] pa;
      logic signed [127:0] pb;
      logic signed [127:0] pr;
      pa = 128'(a);
      pb = 128'(b);
      pr = (pa * pb) >>> s;
      return pr[63:0];
   endfunction

   // Inverse CORDIC gain in Q61 after the given number of steps.
   function automatic logic signed [63:0] gain_inv(input int steps);
      logic signed [63:0] p;
      logic signed [63:0] y;
      logic signed [63:0] y2;
      logic signed [63:0] t;
      p = ONE_Q61;
      y = GAIN_SEED;
      y2 = '0;
      t = '0;
      for (int i = 0; i < 32; i++) begin
         if (i < steps) begin
            p = p + (p >>> (2 * i));
         end
      end
      // Newton steps toward 1 / sqrt(p).
      for (int n = 0; n < 8; n++) begin
         y2 = mul_shift_c(y, y, 61);
         t = THREE_Q61 - mul_shift_c(p, y2, 61);
         y = mul_shift_c(y, t, 62);
      end
      return y;
   endfunction

endpackage
`default_nettype wire

// File: src/principal_axis_rotation.sv
`default_nettype none
// ---------------------------------------------------------------------------
// principal_axis_rotation: rotates a 3D point about the X, Y or Z axis
// Signed Q16.16 point, binary angle, rounded and saturated result.
// ---------------------------------------------------------------------------
// Usage:
//  The req_ channel takes one word per cycle: opcode (axis), angle and the
//  point; the rsp_ channel returns the rotated point and a saturation flag.
//  Both channels use valid and ready; a word moves when both are high.
//  A word runs through the input register, the CORDIC cells, the multipliers
//  and the output register. One word per cycle is sustained while the
//  receiver keeps up: the chain of CORDIC cells holds one word per cell, and
//  the fixed multipliers behind it are pipelined in three stages each.
//  When the receiver stalls, the output register holds its word and a skid
//  register takes one more; only then is req_ready dropped and the whole
//  pipeline frozen until the receiver takes the word in the output register.
//  Reset clears all valid bits; nothing is in flight afterward and
//  req_ready is high from the first cycle.
//  Opcode 3 passes the point through with the flag clear.
// ---------------------------------------------------------------------------
module principal_axis_rotation #(
   parameter int COORD_WIDTH = par_pkg::DEF_COORD_WIDTH,
   parameter int ANGLE_WIDTH = par_pkg::DEF_ANGLE_WIDTH,
   parameter int ITERATIONS  = par_pkg::DEF_ITERATIONS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic        [1:0]             req_opcode,
   input  wire logic        [ANGLE_WIDTH-1:0] req_angle,
   input  wire logic signed [COORD_WIDTH-1:0] req_x_in,
   input  wire logic signed [COORD_WIDTH-1:0] req_y_in,
   input  wire logic signed [COORD_WIDTH-1:0] req_z_in,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic signed      [COORD_WIDTH-1:0] rsp_x_out,
   output logic signed      [COORD_WIDTH-1:0] rsp_y_out,
   output logic signed      [COORD_WIDTH-1:0] rsp_z_out,
   output logic                               rsp_saturated
);

   import par_pkg::*;

   localparam int CW         = COORD_WIDTH;
   localparam int R_WIDTH    = ANGLE_WIDTH - 2;
   localparam int CTX_WIDTH  = 4 + 3 * CW;
   localparam int TAIL_WIDTH = 2 + 3 * CW;
   localparam int WORD_WIDTH = 1 + 3 * CW;
   localparam int PIPE_DEPTH = ITERATIONS + 12;

   // Angle step per unit of the residual bits, and the gain correction.
   localparam logic [62-ANGLE_WIDTH:0] PI_STEP  = PI_Q60[61:ANGLE_WIDTH-1];
   localparam logic signed [63:0]      GAIN_K   = gain_inv(ITERATIONS);
   localparam logic signed [63:0]      COORD_MAX = (64'sd1 <<< (CW - 1)) - 64'sd1;
   localparam logic signed [63:0]      COORD_MIN = -COORD_MAX - 64'sd1;
   localparam logic signed [63:0]      ROUND_HALF = 64'sd128;

   logic                    adv;
   logic [PIPE_DEPTH-1:0]   vld_ff;

   logic [60:0]             ang_prod;
   logic [60:0]             ang0_ff;
   logic [CTX_WIDTH-1:0]    ctx0_ff;

   cordic_type              chain_vec [ITERATIONS+1];
   logic [CTX_WIDTH-1:0]    chain_ctx [ITERATIONS+1];
   cordic_type              end_vec;

   logic signed [63:0]      dx;
   logic signed [63:0]      dy;
   logic [127:0]            cxy_d;
   logic [CTX_WIDTH-1:0]    ctx_q;
   logic signed [63:0]      rx_ff;
   logic signed [63:0]      ry_ff;
   logic signed [63:0]      c_val;
   logic signed [63:0]      s_val;

   logic [1:0]              q_opcode;
   logic [1:0]              q_quad;
   logic signed [CW-1:0]    q_x;
   logic signed [CW-1:0]    q_y;
   logic signed [CW-1:0]    q_z;
   logic signed [63:0]      co;
   logic signed [63:0]      si;
   logic signed [CW-1:0]    u;
   logic signed [CW-1:0]    v;
   logic signed [63:0]      co_ff;
   logic signed [63:0]      si_ff;
   logic signed [63:0]      nsi_ff;
   logic signed [CW-1:0]    u_ff;
   logic signed [CW-1:0]    v_ff;
   logic [TAIL_WIDTH-1:0]   tail_ff;
   logic [TAIL_WIDTH-1:0]   tail_d;

   logic signed [63:0]      pa;
   logic signed [63:0]      pb;
   logic signed [63:0]      pc;
   logic signed [63:0]      pd;
   logic [CW:0]             u_res;
   logic [CW:0]             v_res;
   logic [1:0]              t_opcode;
   logic [CW-1:0]           res_x;
   logic [CW-1:0]           res_y;
   logic [CW-1:0]           res_z;
   logic                    res_sat;
   logic [WORD_WIDTH-1:0]   res_word;

   logic                    deliver;
   logic                    take;
   logic                    out_vld_ff;
   logic                    out_vld_in;
   logic [WORD_WIDTH-1:0]   out_word_ff;
   logic [WORD_WIDTH-1:0]   out_word_in;
   logic                    skid_vld_ff;
   logic                    skid_vld_in;
   logic [WORD_WIDTH-1:0]   skid_word_ff;
   logic [WORD_WIDTH-1:0]   skid_word_in;

   // Sum of two products, rounded to Q16.16 and clamped; the top bit flags a clamp.
   function automatic logic [CW:0] round_clamp(input logic signed [63:0] ma,
                                               input logic signed [63:0] mb);
      logic signed [63:0] sum;
      logic signed [63:0] rnd;
      sum = ma + mb + ROUND_HALF;
      rnd = sum >>> 8;
      priority if (rnd > COORD_MAX) begin
         return {1'b1, COORD_MAX[CW-1:0]};
      end else if (rnd < COORD_MIN) begin
         return {1'b1, COORD_MIN[CW-1:0]};
      end else begin
         return {1'b0, rnd[CW-1:0]};
      end
   endfunction

   // The pipeline moves whenever the skid register is free.
   assign adv       = ~skid_vld_ff;
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[PIPE_DEPTH-2:0], req_valid};
      end
   end

   // Input stage: residual angle bits scaled to radians in Q60.
   assign ang_prod = 61'(req_angle[R_WIDTH-1:0]) * 61'(PI_STEP);

   always_ff @(posedge clock) begin
      if (adv) begin
         ang0_ff <= ang_prod;
         ctx0_ff <= {req_opcode, req_angle[ANGLE_WIDTH-1 -: 2], req_x_in, req_y_in, req_z_in};
      end
   end

   // Chain of CORDIC cells, starting from the unit vector along X.
   assign chain_vec[0].cx  = ONE_Q61;
   assign chain_vec[0].cy  = '0;
   assign chain_vec[0].ang = $signed({3'b000, ang0_ff});
   assign chain_ctx[0]     = ctx0_ff;

   for (genvar i = 0; i < ITERATIONS; i++) begin : g_cell
      par_cell #(
         .STAGE     (i),
         .CTX_WIDTH (CTX_WIDTH)
      ) u_cell (
         .clock    (clock),
         .adv      (adv),
         .prev_vec (chain_vec[i]),
         .prev_ctx (chain_ctx[i]),
         .next_vec (chain_vec[i+1]),
         .next_ctx (chain_ctx[i+1])
      );
   end

   assign end_vec = chain_vec[ITERATIONS];

   // First-order correction for the angle left after the last cell.
   par_mul #(.A_WIDTH(64), .B_WIDTH(64), .SHIFT(60)) u_mul_dx (
      .clock (clock), .adv (adv), .a (end_vec.cy), .b (end_vec.ang), .p (dx)
   );

   par_mul #(.A_WIDTH(64), .B_WIDTH(64), .SHIFT(60)) u_mul_dy (
      .clock (clock), .adv (adv), .a (end_vec.cx), .b (end_vec.ang), .p (dy)
   );

   par_delay #(.WIDTH(128), .DEPTH(3)) u_delay_xy (
      .clock (clock), .adv (adv), .d ({end_vec.cx, end_vec.cy}), .q (cxy_d)
   );

   par_delay #(.WIDTH(CTX_WIDTH), .DEPTH(7)) u_delay_ctx (
      .clock (clock), .adv (adv), .d (chain_ctx[ITERATIONS]), .q (ctx_q)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         rx_ff <= $signed(cxy_d[127:64]) - dx;
         ry_ff <= $signed(cxy_d[63:0]) + dy;
      end
   end

   // Remove the CORDIC gain to get cosine and sine in Q61.
   par_mul #(.A_WIDTH(64), .B_WIDTH(64), .SHIFT(61)) u_mul_c (
      .clock (clock), .adv (adv), .a (rx_ff), .b (GAIN_K), .p (c_val)
   );

   par_mul #(.A_WIDTH(64), .B_WIDTH(64), .SHIFT(61)) u_mul_s (
      .clock (clock), .adv (adv), .a (ry_ff), .b (GAIN_K), .p (s_val)
   );

   // Quadrant mapping and choice of the coordinate pair to rotate.
   assign q_opcode = ctx_q[CTX_WIDTH-1 -: 2];
   assign q_quad   = ctx_q[CTX_WIDTH-3 -: 2];
   assign q_x      = $signed(ctx_q[3*CW-1 -: CW]);
   assign q_y      = $signed(ctx_q[2*CW-1 -: CW]);
   assign q_z      = $signed(ctx_q[CW-1:0]);

   always_comb begin
      unique case (q_quad)
         QUAD_0: begin
            co = c_val;
            si = s_val;
         end
         QUAD_1: begin
            co = -s_val;
            si = c_val;
         end
         QUAD_2: begin
            co = -c_val;
            si = -s_val;
         end
         QUAD_3: begin
            co = s_val;
            si = -c_val;
         end
      endcase
      // The pair (u, v) turns as u' = u*cos - v*sin, v' = u*sin + v*cos.
      unique case (q_opcode)
         AXIS_X: begin
            u = q_y;
            v = q_z;
         end
         AXIS_Y: begin
            u = q_z;
            v = q_x;
         end
         AXIS_Z: begin
            u = q_x;
            v = q_y;
         end
         AXIS_NONE: begin
            u = q_x;
            v = q_y;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         co_ff   <= co;
         si_ff   <= si;
         nsi_ff  <= -si;
         u_ff    <= u;
         v_ff    <= v;
         tail_ff <= {q_opcode, ctx_q[3*CW-1:0]};
      end
   end

   // Four products with 8 guard bits below the Q16.16 point.
   par_mul #(.A_WIDTH(CW), .B_WIDTH(64), .SHIFT(53)) u_mul_a (
      .clock (clock), .adv (adv), .a (u_ff), .b (co_ff), .p (pa)
   );

   par_mul #(.A_WIDTH(CW), .B_WIDTH(64), .SHIFT(53)) u_mul_b (
      .clock (clock), .adv (adv), .a (v_ff), .b (nsi_ff), .p (pb)
   );

   par_mul #(.A_WIDTH(CW), .B_WIDTH(64), .SHIFT(53)) u_mul_c2 (
      .clock (clock), .adv (adv), .a (u_ff), .b (si_ff), .p (pc)
   );

   par_mul #(.A_WIDTH(CW), .B_WIDTH(64), .SHIFT(53)) u_mul_d (
      .clock (clock), .adv (adv), .a (v_ff), .b (co_ff), .p (pd)
   );

   par_delay #(.WIDTH(TAIL_WIDTH), .DEPTH(3)) u_delay_tail (
      .clock (clock), .adv (adv), .d (tail_ff), .q (tail_d)
   );

   // Round, clamp and put the rotated pair back in place.
   assign t_opcode = tail_d[TAIL_WIDTH-1 -: 2];

   always_comb begin
      u_res   = round_clamp(pa, pb);
      v_res   = round_clamp(pc, pd);
      res_x   = tail_d[3*CW-1 -: CW];
      res_y   = tail_d[2*CW-1 -: CW];
      res_z   = tail_d[CW-1:0];
      res_sat = 1'b0;
      unique case (t_opcode)
         AXIS_X: begin
            res_y   = u_res[CW-1:0];
            res_z   = v_res[CW-1:0];
            res_sat = u_res[CW] | v_res[CW];
         end
         AXIS_Y: begin
            res_z   = u_res[CW-1:0];
            res_x   = v_res[CW-1:0];
            res_sat = u_res[CW] | v_res[CW];
         end
         AXIS_Z: begin
            res_x   = u_res[CW-1:0];
            res_y   = v_res[CW-1:0];
            res_sat = u_res[CW] | v_res[CW];
         end
         AXIS_NONE: begin
            res_sat = 1'b0;
         end
      endcase
   end

   assign res_word = {res_sat, res_x, res_y, res_z};

   // Output register with a skid register behind it.
   assign deliver = adv & vld_ff[PIPE_DEPTH-1];
   assign take    = out_vld_ff & rsp_ready;

   always_comb begin
      out_vld_in   = out_vld_ff;
      out_word_in  = out_word_ff;
      skid_vld_in  = skid_vld_ff;
      skid_word_in = skid_word_ff;
      priority if (skid_vld_ff) begin
         if (take) begin
            out_word_in = skid_word_ff;
            skid_vld_in = 1'b0;
         end
      end else if (deliver) begin
         if (!out_vld_ff || take) begin
            out_vld_in  = 1'b1;
            out_word_in = res_word;
         end else begin
            skid_vld_in  = 1'b1;
            skid_word_in = res_word;
         end
      end else if (take) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_word_ff  <= out_word_in;
      skid_word_ff <= skid_word_in;
   end

   assign rsp_valid     = out_vld_ff;
   assign rsp_saturated = out_word_ff[WORD_WIDTH-1];
   assign rsp_x_out     = $signed(out_word_ff[3*CW-1 -: CW]);
   assign rsp_y_out     = $signed(out_word_ff[2*CW-1 -: CW]);
   assign rsp_z_out     = $signed(out_word_ff[CW-1:0]);

endmodule
`default_nettype wire

// File: src/par_delay.sv
`default_nettype none
// ---------------------------------------------------------------------------
// par_delay: stalling delay line
// Moves a word of side data through DEPTH registers, one step each cycle
// in which the pipeline advances.
// ---------------------------------------------------------------------------
module par_delay #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 3
) (
   input  wire logic             clock,
   input  wire logic             adv,
   input  wire logic [WIDTH-1:0] d,
   output logic      [WIDTH-1:0] q
);

   logic [WIDTH-1:0] stage_ff [DEPTH];

   // Shift the line when the pipeline moves.
   always_ff @(posedge clock) begin
      if (adv) begin
         stage_ff[0] <= d;
         for (int i = 1; i < DEPTH; i++) begin
            stage_ff[i] <= stage_ff[i-1];
         end
      end
   end

   assign q = stage_ff[DEPTH-1];

endmodule
`default_nettype wire

// File: src/par_mul.sv
`default_nettype none
// ---------------------------------------------------------------------------
// par_mul: three-stage signed multiplier with a fixed right shift
// Splits both operands into 32-bit halves, registers the four partial
// products, then sums them over two stages and returns the floor of
// a*b / 2^SHIFT in 64 bits.
// ---------------------------------------------------------------------------
module par_mul #(
   parameter int A_WIDTH = 64,
   parameter int B_WIDTH = 64,
   parameter int SHIFT   = 60
) (
   input  wire logic                      clock,
   input  wire logic                      adv,
   input  wire logic signed [A_WIDTH-1:0] a,
   input  wire logic signed [B_WIDTH-1:0] b,
   output logic signed      [63:0]        p
);

   logic signed [63:0]  a64;
   logic signed [63:0]  b64;
   logic signed [63:0]  phh_ff;
   logic signed [64:0]  phl_ff;
   logic signed [64:0]  plh_ff;
   logic        [63:0]  pll_ff;
   logic signed [127:0] cat_ff;
   logic signed [65:0]  mid_ff;
   logic signed [127:0] mid_wide;
   logic signed [127:0] prod;
   logic signed [63:0]  p_ff;

   assign a64 = 64'(a);
   assign b64 = 64'(b);

   // Stage one: partial products of the high and low halves.
   always_ff @(posedge clock) begin
      if (adv) begin
         phh_ff <= $signed(a64[63:32]) * $signed(b64[63:32]);
         phl_ff <= $signed(a64[63:32]) * $signed({1'b0, b64[31:0]});
         plh_ff <= $signed({1'b0, a64[31:0]}) * $signed(b64[63:32]);
         pll_ff <= a64[31:0] * b64[31:0];
      end
   end

   // Stage two: the outer products do not overlap; the cross terms add.
   always_ff @(posedge clock) begin
      if (adv) begin
         cat_ff <= $signed({phh_ff, pll_ff});
         mid_ff <= 66'(phl_ff) + 66'(plh_ff);
      end
   end

   // Stage three: full product and the shifted result.
   assign mid_wide = 128'(mid_ff);
   assign prod     = cat_ff + (mid_wide <<< 32);

   always_ff @(posedge clock) begin
      if (adv) begin
         p_ff <= $signed(prod[SHIFT+63:SHIFT]);
      end
   end

   assign p = p_ff;

endmodule
`default_nettype wire

// File: src/par_cell.sv
`default_nettype none
// ---------------------------------------------------------------------------
// par_cell: one CORDIC rotation step
// Turns the vector by the arctangent of 2^-STAGE toward a zero residual
// angle and passes the vector and the side data to the next cell.
// ---------------------------------------------------------------------------
module par_cell #(
   parameter int STAGE     = 0,
   parameter int CTX_WIDTH = 8
) (
   input  wire logic                 clock,
   input  wire logic                 adv,
   input  wire par_pkg::cordic_type  prev_vec,
   input  wire logic [CTX_WIDTH-1:0] prev_ctx,
   output par_pkg::cordic_type       next_vec,
   output logic      [CTX_WIDTH-1:0] next_ctx
);

   import par_pkg::*;

   localparam logic signed [63:0] ATAN = atan_q60(STAGE);

   logic signed [63:0]   cx;
   logic signed [63:0]   cy;
   logic signed [63:0]   ang;
   logic signed [63:0]   sx;
   logic signed [63:0]   sy;
   cordic_type           vec_in;
   cordic_type           vec_ff;
   logic [CTX_WIDTH-1:0] ctx_ff;

   assign cx  = prev_vec.cx;
   assign cy  = prev_vec.cy;
   assign ang = prev_vec.ang;
   assign sx  = cx >>> STAGE;
   assign sy  = cy >>> STAGE;

   // Direction follows the sign of the residual angle.
   always_comb begin
      if (ang >= 0) begin
         vec_in.cx  = cx - sy;
         vec_in.cy  = cy + sx;
         vec_in.ang = ang - ATAN;
      end else begin
         vec_in.cx  = cx + sy;
         vec_in.cy  = cy - sx;
         vec_in.ang = ang + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         vec_ff <= vec_in;
         ctx_ff <= prev_ctx;
      end
   end

   assign next_vec = vec_ff;
   assign next_ctx = ctx_ff;

endmodule
`default_nettype wire

// File: tb/sv/principal_axis_rotation_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// principal_axis_rotation_tb: self-checking bench for the axis rotation block
// Drives points with random axis and angle through the req_ channel and
// compares every rsp_ word, field by field, with a bit-exact CORDIC
// predictor kept in the bench. Both sides idle at random, and the receiver
// holds off long enough to fill the pipeline and stall the sender.
// ---------------------------------------------------------------------------
module principal_axis_rotation_tb;
   import par_pkg::*;

   localparam int CW    = DEF_COORD_WIDTH;
   localparam int AW    = DEF_ANGLE_WIDTH;
   localparam int STEPS = DEF_ITERATIONS;

   // Pipeline latency plus margin, used for the final quiet period.
   localparam int DRAIN_CYCLES = DEF_ITERATIONS + 12 + 34;
   localparam int IDLE_LIMIT   = 3000;
   localparam int HOLD_CYCLES  = 300;

   localparam longint COORD_MAX = (64'sd1 <<< (CW - 1)) - 1;
   localparam longint COORD_MIN = -COORD_MAX - 1;

   localparam logic signed [CW-1:0] COORD_HI = {1'b0, {(CW - 1){1'b1}}};
   localparam logic signed [CW-1:0] COORD_LO = {1'b1, {(CW - 1){1'b0}}};
   localparam logic signed [CW-1:0] Q_ONE    = 1 <<< 16;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] z;
      logic                 sat;
   } point_word_type;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [1:0] req_opcode;
   logic [AW-1:0] req_angle;
   logic signed [CW-1:0] req_x_in;
   logic signed [CW-1:0] req_y_in;
   logic signed [CW-1:0] req_z_in;
   logic rsp_valid;
   logic rsp_ready;
   logic signed [CW-1:0] rsp_x_out;
   logic signed [CW-1:0] rsp_y_out;
   logic signed [CW-1:0] rsp_z_out;
   logic rsp_saturated;

   // Arctangent steps in Q60 and the gain compensation factor in Q61.
   longint atan_steps_q60[STEPS];
   longint gain_comp_q61;

   point_word_type expected_points[$];
   bit tx_gaps;
   bit rx_gaps;
   bit hold_output;
   int rx_wait;
   int mismatches;
   int idle_cycles;

   principal_axis_rotation dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_opcode    (req_opcode),
      .req_angle     (req_angle),
      .req_x_in      (req_x_in),
      .req_y_in      (req_y_in),
      .req_z_in      (req_z_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_x_out     (rsp_x_out),
      .rsp_y_out     (rsp_y_out),
      .rsp_z_out     (rsp_z_out),
      .rsp_saturated (rsp_saturated)
   );

   always #6 clock = ~clock;

   // Floor of a*b / 2^s, taken from the full 128-bit product.
   function automatic longint mul_floor(input longint a, input longint b, input int s);
      logic signed [127:0] wa;
      logic signed [127:0] wb;
      logic signed [127:0] prod;
      wa = a;
      wb = b;
      prod = (wa * wb) >>> s;
      return prod[63:0];
   endfunction

   // Fills the arctangent steps from the alternating series and finds the
   // inverse gain by Newton iteration toward 1/sqrt of the squared gain.
   function automatic void build_cordic_constants();
      longint series;
      longint term;
      longint gain_sq;
      longint est;
      longint est_sq;
      atan_steps_q60[0] = PI_Q60 >>> 2;
      for (int i = 1; i < STEPS; i++) begin
         series = 0;
         for (int k = 0; i * (2 * k + 1) <= 60; k++) begin
            term = (64'sd1 <<< (60 - i * (2 * k + 1))) / (2 * k + 1);
            series = (k % 2 == 1) ? series - term : series + term;
         end
         atan_steps_q60[i] = series;
      end
      gain_sq = ONE_Q61;
      for (int i = 0; i < STEPS; i++) begin
         gain_sq = gain_sq + (gain_sq >>> (2 * i));
      end
      est = (64'sd3 * ONE_Q61) / 5;
      for (int n = 0; n < 8; n++) begin
         est_sq = mul_floor(est, est, 61);
         est = mul_floor(est, 64'sd3 * ONE_Q61 - mul_floor(gain_sq, est_sq, 61), 62);
      end
      gain_comp_q61 = est;
   endfunction

   // Weighted sum of two coordinates with 8 guard bits, rounded and clamped.
   // The top bit of the return value flags a clamp.
   function automatic logic [CW:0] mix_round(input longint p, input longint cp,
                                             input longint q, input longint cq);
      longint v;
      logic clipped;
      clipped = 1'b0;
      v = mul_floor(p, cp, 53) + mul_floor(q, cq, 53);
      v = (v + 128) >>> 8;
      if (v > COORD_MAX) begin
         clipped = 1'b1;
         v = COORD_MAX;
      end else if (v < COORD_MIN) begin
         clipped = 1'b1;
         v = COORD_MIN;
      end
      return {clipped, v[CW-1:0]};
   endfunction

   // Expected rotated point for one request word.
   function automatic point_word_type predict_rotation(input logic [1:0] op,
                                                       input logic [AW-1:0] ang,
                                                       input logic signed [CW-1:0] x,
                                                       input logic signed [CW-1:0] y,
                                                       input logic signed [CW-1:0] z);
      longint px, py, pz;
      longint cx, cy, resid, sx, sy, dx, dy;
      longint c, s, co, si;
      logic [CW:0] ra;
      logic [CW:0] rb;
      point_word_type w;
      px = x;
      py = y;
      pz = z;
      ra = '0;
      rb = '0;
      cx = ONE_Q61;
      cy = 0;
      resid = longint'(ang[AW-3:0]) * (PI_Q60 >>> (AW - 1));
      // Rotation-mode CORDIC on the angle within the quadrant.
      for (int i = 0; i < STEPS; i++) begin
         sx = cx >>> i;
         sy = cy >>> i;
         if (resid >= 0) begin
            cx = cx - sy;
            cy = cy + sx;
            resid = resid - atan_steps_q60[i];
         end else begin
            cx = cx + sy;
            cy = cy - sx;
            resid = resid + atan_steps_q60[i];
         end
      end
      // First-order correction for the residual angle, then gain removal.
      dx = mul_floor(cy, resid, 60);
      dy = mul_floor(cx, resid, 60);
      cx = cx - dx;
      cy = cy + dy;
      c = mul_floor(cx, gain_comp_q61, 61);
      s = mul_floor(cy, gain_comp_q61, 61);
      case (ang[AW-1:AW-2])
         QUAD_0: begin
            co = c;
            si = s;
         end
         QUAD_1: begin
            co = -s;
            si = c;
         end
         QUAD_2: begin
            co = -c;
            si = -s;
         end
         default: begin
            co = s;
            si = -c;
         end
      endcase
      w.x = x;
      w.y = y;
      w.z = z;
      w.sat = 1'b0;
      case (op)
         AXIS_X: begin
            ra = mix_round(py, co, pz, -si);
            rb = mix_round(py, si, pz, co);
            w.y = ra[CW-1:0];
            w.z = rb[CW-1:0];
         end
         AXIS_Y: begin
            ra = mix_round(px, co, pz, si);
            rb = mix_round(px, -si, pz, co);
            w.x = ra[CW-1:0];
            w.z = rb[CW-1:0];
         end
         AXIS_Z: begin
            ra = mix_round(px, co, py, -si);
            rb = mix_round(px, si, py, co);
            w.x = ra[CW-1:0];
            w.y = rb[CW-1:0];
         end
         default: begin
         end
      endcase
      w.sat = ra[CW] | rb[CW];
      return w;
   endfunction

   // Idle length: mostly a short idle, now and then a long pause.
   function automatic int pick_gap();
      if ($urandom_range(0, 99) < 85) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 60);
   endfunction

   // Coordinate mix: full range, small values, mid-size values and extremes.
   function automatic logic signed [CW-1:0] rand_coord();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return $urandom;
         4, 5, 6: return int'($urandom_range(0, 2097152)) - 1048576;
         7: return int'($urandom_range(0, 536870912)) - 268435456;
         8: begin
            case ($urandom_range(0, 3))
               0: return COORD_HI;
               1: return COORD_LO;
               2: return '0;
               default: return '1;
            endcase
         end
         default: return int'($urandom_range(0, 131072)) - 65536;
      endcase
   endfunction

   // Offers one request word and holds it until accepted; when gaps are
   // enabled, it now and then idles the sender for a random stretch.
   task automatic send_point(input logic [1:0] op, input logic [AW-1:0] ang,
                             input logic signed [CW-1:0] x,
                             input logic signed [CW-1:0] y,
                             input logic signed [CW-1:0] z);
      int gap;
      @(negedge clock);
      req_opcode = op;
      req_angle = ang;
      req_x_in = x;
      req_y_in = y;
      req_z_in = z;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      expected_points.push_back(predict_rotation(op, ang, x, y, z));
      gap = (tx_gaps && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic send_random();
      send_point(2'($urandom_range(0, 3)), AW'($urandom), rand_coord(), rand_coord(),
                 rand_coord());
   endtask

   // Every axis at each quadrant boundary, plus the largest angle and 45 degrees.
   task automatic test_axis_corners();
      logic [1:0] axes[3];
      axes = '{AXIS_X, AXIS_Y, AXIS_Z};
      foreach (axes[a]) begin
         for (int q = 0; q < 4; q++) begin
            send_point(axes[a], AW'(q) << (AW - 2), Q_ONE, 2 * Q_ONE, -3 * Q_ONE);
         end
      end
      send_point(AXIS_Z, '1, -Q_ONE, Q_ONE / 2, 7 * Q_ONE);
      send_point(AXIS_Y, AW'(1) << (AW - 3), 5 * Q_ONE, -Q_ONE, Q_ONE);
   endtask

   // Points at the range limits rotated so that a coordinate must clamp.
   task automatic test_saturation();
      send_point(AXIS_Z, AW'(1) << (AW - 3), COORD_HI, COORD_HI, COORD_HI);
      send_point(AXIS_X, AW'(1) << (AW - 3), COORD_LO, COORD_LO, COORD_HI);
      send_point(AXIS_Y, AW'(1) << (AW - 1), COORD_LO, '0, COORD_LO);
      send_point(AXIS_X, AW'(3) << (AW - 3), COORD_HI, COORD_LO, COORD_HI);
   endtask

   // The unused opcode passes the point through; a zero point stays zero.
   task automatic test_passthrough();
      send_point(AXIS_NONE, '1, COORD_HI, COORD_LO, '0);
      send_point(AXIS_NONE, '0, COORD_LO, COORD_HI, '1);
      send_point(AXIS_NONE, AW'($urandom), rand_coord(), rand_coord(), rand_coord());
      send_point(AXIS_Z, AW'(16'h1234), '0, '0, '0);
   endtask

   task automatic test_random_streaming(input int count);
      tx_gaps = 1'b0;
      rx_gaps = 1'b0;
      repeat (count) send_random();
   endtask

   task automatic test_random_with_gaps(input int count);
      tx_gaps = 1'b1;
      rx_gaps = 1'b1;
      repeat (count) send_random();
   endtask

   task automatic test_sender_gaps_only(input int count);
      tx_gaps = 1'b1;
      rx_gaps = 1'b0;
      repeat (count) send_random();
   endtask

   // The receiver holds off while words keep coming, so the pipeline fills
   // and the block must stall its input.
   task automatic test_output_stall(input int count);
      tx_gaps = 1'b0;
      rx_gaps = 1'b0;
      send_random();
      hold_output = 1'b1;
      repeat (count) send_random();
   endtask

   // Receiver: a long hold when asked, otherwise random stalls when enabled.
   always begin
      @(negedge clock);
      if (hold_output) begin
         rsp_ready = 1'b0;
         repeat (HOLD_CYCLES) @(negedge clock);
         hold_output = 1'b0;
      end else if (rx_wait > 0) begin
         rsp_ready = 1'b0;
         rx_wait--;
      end else begin
         rsp_ready = 1'b1;
         if (rx_gaps && $urandom_range(0, 99) < 20) begin
            rx_wait = pick_gap();
         end
      end
   end

   // Checks each accepted result word against the oldest expected point.
   always @(posedge clock) begin
      point_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_points.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected result word: x %h y %h z %h sat %b",
                        rsp_x_out, rsp_y_out, rsp_z_out, rsp_saturated);
            end
         end else begin
            want = expected_points.pop_front();
            if (rsp_x_out !== want.x || rsp_y_out !== want.y || rsp_z_out !== want.z ||
                rsp_saturated !== want.sat) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("result mismatch (expected/actual): x %h/%h y %h/%h z %h/%h sat %b/%b",
                           want.x, rsp_x_out, want.y, rsp_y_out, want.z, rsp_z_out,
                           want.sat, rsp_saturated);
               end
            end
         end
      end
   end

   // Watchdog: ends the run after too many cycles without any handshake.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_opcode = AXIS_X;
      req_angle = '0;
      req_x_in = '0;
      req_y_in = '0;
      req_z_in = '0;
      rsp_ready = 1'b0;
      tx_gaps = 1'b0;
      rx_gaps = 1'b0;
      hold_output = 1'b0;
      rx_wait = 0;
      mismatches = 0;
      idle_cycles = 0;
      build_cordic_constants();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_axis_corners();
      test_saturation();
      test_passthrough();
      test_random_streaming(400);
      test_output_stall(150);
      test_random_with_gaps(900);
      test_sender_gaps_only(300);

      // Drop the last word, drain the pipeline and watch for stray results.
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_points.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
